// ===== rtl/yuv2rgb_pkg.sv =====
package yuv2rgb_pkg;

    // widths
    localparam int CfgW  = 9;
    localparam int SampW = 8;
    localparam int NormW = 14;
    localparam int CompW = 15;
    localparam int SumW  = 28;
    localparam int ClipW = 25;

    // q12 normalization and bt.601 matrix constants
    localparam int Q_ONE    = 4096;
    localparam int U_SCALE  = 3572;
    localparam int U_BIAS   = 1786;
    localparam int V_SCALE  = 5038;
    localparam int V_BIAS   = 2519;
    localparam int K_RV     = 4669;
    localparam int K_GU     = 1616;
    localparam int K_GV     = 2378;
    localparam int K_BU     = 8324;
    localparam int NORM_DIV = 510;

    localparam logic signed [SumW-1:0] SUM_MAX = 28'sd16777216;

    // register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_LUMA_OFFSET = 2'd0;
    localparam cfg_index_t REG_BLUE_OFFSET = 2'd1;
    localparam cfg_index_t REG_RED_OFFSET  = 2'd2;

    typedef struct packed {
        logic signed [CfgW-1:0] luma;
        logic signed [CfgW-1:0] blue;
        logic signed [CfgW-1:0] red;
    } offsets_t;

    typedef logic signed [NormW-1:0] norm_t;
    typedef norm_t norm_tbl_t [256];

    // round(s * scale / 255) - bias for every 8-bit sample, built at elaboration
    function automatic norm_tbl_t build_norm(input int scale, input int bias);
        norm_tbl_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = NormW'((i * scale * 2 + 255) / NORM_DIV - bias);
        end
        return t;
    endfunction

    localparam norm_tbl_t Y_TBL = build_norm(Q_ONE, 0);
    localparam norm_tbl_t U_TBL = build_norm(U_SCALE, U_BIAS);
    localparam norm_tbl_t V_TBL = build_norm(V_SCALE, V_BIAS);

    // clamp a q24 sum to [0, 1.0] and scale by 255 with truncation
    function automatic logic [SampW-1:0] to_channel(input logic signed [SumW-1:0] sum);
        logic [ClipW-1:0] c;
        logic [ClipW+SampW-1:0] p;
        if (sum < 0) begin
            c = '0;
        end else if (sum > SUM_MAX) begin
            c = SUM_MAX[ClipW-1:0];
        end else begin
            c = sum[ClipW-1:0];
        end
        p = {c, 8'b0} - {8'b0, c};
        return p[ClipW+SampW-2:ClipW-1];
    endfunction

endpackage

// ===== rtl/yuv2rgb_matrix.sv =====
module yuv2rgb_matrix (
    input  logic [7:0]           luma,
    input  logic [7:0]           chroma_blue,
    input  logic [7:0]           chroma_red,
    input  yuv2rgb_pkg::offsets_t offs,
    output logic [7:0]           red,
    output logic [7:0]           green,
    output logic [7:0]           blue
);
    import yuv2rgb_pkg::*;

    logic signed [CompW-1:0] y_q;
    logic signed [CompW-1:0] u_q;
    logic signed [CompW-1:0] v_q;
    logic signed [SumW-1:0]  y_w;
    logic signed [SumW-1:0]  rv;
    logic signed [SumW-1:0]  gu;
    logic signed [SumW-1:0]  gv;
    logic signed [SumW-1:0]  bu;

    // normalized samples plus offsets (offset lsb is 1/256, so shift by 4 into q12)
    always_comb
    begin
        y_q = CompW'(Y_TBL[luma])        + CompW'($signed({offs.luma, 4'b0000}));
        u_q = CompW'(U_TBL[chroma_blue]) + CompW'($signed({offs.blue, 4'b0000}));
        v_q = CompW'(V_TBL[chroma_red])  + CompW'($signed({offs.red,  4'b0000}));
    end

    // constant-coefficient products in q24
    always_comb
    begin
        y_w = SumW'(y_q) <<< 12;
        rv  = SumW'(v_q) * SumW'(K_RV);
        gu  = SumW'(u_q) * SumW'(K_GU);
        gv  = SumW'(v_q) * SumW'(K_GV);
        bu  = SumW'(u_q) * SumW'(K_BU);
    end

    assign red   = to_channel(y_w + rv);
    assign green = to_channel(y_w - gu - gv);
    assign blue  = to_channel(y_w + bu);

endmodule

// ===== rtl/yuv_to_rgb_pixel_converter_core.sv =====
// channel | direction | handshake             | payload
// --------+-----------+-----------------------+-----------------------------------
// in      | input     | in_valid / in_stall   | luma, chroma_blue, chroma_red
// out     | output    | out_valid / out_stall | red, green, blue
// cfg     | input     | cfg_we                | cfg_index, cfg_data (9-bit signed)
//
// one pixel per clock sustained while out_stall is low; a taken beat passes through the
// input register, then the result register, to the output
// the matrix is pure combinational logic between the two registers
// reset clears the offsets to zero and both valid flags
// in_stall rises only when the input register holds a pixel that cannot move
// because the result register is full and stalled
module yuv_to_rgb_pixel_converter_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    luma,
    input  logic [7:0]                    chroma_blue,
    input  logic [7:0]                    chroma_red,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    red,
    output logic [7:0]                    green,
    output logic [7:0]                    blue,
    input  logic                          cfg_we,
    input  yuv2rgb_pkg::cfg_index_t       cfg_index,
    input  logic [yuv2rgb_pkg::CfgW-1:0]  cfg_data
);
    import yuv2rgb_pkg::*;

    // offset registers
    offsets_t   offs_reg;
    offsets_t   offs_next;

    // input stage
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] luma_reg;
    logic [7:0] cb_reg;
    logic [7:0] cr_reg;

    // result stage
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;

    logic       in_take;
    logic       advance;
    logic [7:0] red_c;
    logic [7:0] green_c;
    logic [7:0] blue_c;

    // config writes, index beyond the register list is dropped
    always_comb
    begin
        offs_next = offs_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_LUMA_OFFSET: offs_next.luma = $signed(cfg_data);
                REG_BLUE_OFFSET: offs_next.blue = $signed(cfg_data);
                REG_RED_OFFSET:  offs_next.red  = $signed(cfg_data);
                default:         offs_next      = offs_reg;
            endcase
        end
    end

    // result register is free when empty or being drained this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offs_reg      <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            offs_reg      <= offs_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input beat capture
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            luma_reg <= luma;
            cb_reg   <= chroma_blue;
            cr_reg   <= chroma_red;
        end
    end

    // normalize, offset, matrix, clamp and scale
    yuv2rgb_matrix u_matrix (
        .luma        (luma_reg),
        .chroma_blue (cb_reg),
        .chroma_red  (cr_reg),
        .offs        (offs_reg),
        .red         (red_c),
        .green       (green_c),
        .blue        (blue_c)
    );

    // result beat, held while stalled
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            red_reg   <= red_c;
            green_reg <= green_c;
            blue_reg  <= blue_c;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

// ===== bench/yuv_to_rgb_checker.sv =====
module yuv_to_rgb_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [7:0]                    luma,
    input  logic [7:0]                    chroma_blue,
    input  logic [7:0]                    chroma_red,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    input  logic                          cfg_we,
    input  yuv2rgb_pkg::cfg_index_t       cfg_index,
    input  logic [yuv2rgb_pkg::CfgW-1:0]  cfg_data,
    output int                            mismatches,
    output int                            pending
);
    import yuv2rgb_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    localparam longint OffToQ12 = 16;
    localparam longint SumOne   = longint'(1) << 24;

    offsets_t offsets;
    rgb_t     rgb_expected_q[$];
    int       errors = 0;
    int       depth  = 0;

    assign mismatches = errors;
    assign pending    = depth;

    // round(s * scale / 255) - bias in q12
    function automatic longint normalize(logic [7:0] s, longint scale, longint bias);
        return (longint'(s) * scale * 2 + 255) / NORM_DIV - bias;
    endfunction

    // clamp a q24 sum to [0, 1.0], scale by 255, truncate
    function automatic logic [7:0] scale_channel(longint sum);
        longint c;
        c = sum;
        if (c < 0)
            c = 0;
        if (c > SumOne)
            c = SumOne;
        return 8'((c * 255) >> 24);
    endfunction

    function automatic rgb_t predict_rgb(logic [7:0] y_s, logic [7:0] u_s, logic [7:0] v_s,
                                         offsets_t off);
        longint y;
        longint u;
        longint v;
        longint yq;
        rgb_t   px;
        y  = normalize(y_s, Q_ONE, 0) + longint'(off.luma) * OffToQ12;
        u  = normalize(u_s, U_SCALE, U_BIAS) + longint'(off.blue) * OffToQ12;
        v  = normalize(v_s, V_SCALE, V_BIAS) + longint'(off.red) * OffToQ12;
        yq = y * Q_ONE;
        px.red   = scale_channel(yq + K_RV * v);
        px.green = scale_channel(yq - K_GU * u - K_GV * v);
        px.blue  = scale_channel(yq + K_BU * u);
        return px;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rgb_t want;
        if (!rst_n)
        begin
            offsets = '0;
            rgb_expected_q.delete();
            depth = 0;
        end
        else
        begin
            // result side first, then the new pixel, then register writes
            if (out_valid && !out_stall)
            begin
                if (rgb_expected_q.size() == 0)
                begin
                    $error("rgb beat with no pixel pending: red %0d green %0d blue %0d",
                           red, green, blue);
                    errors++;
                end
                else
                begin
                    want = rgb_expected_q.pop_front();
                    check_field("red", want.red, red);
                    check_field("green", want.green, green);
                    check_field("blue", want.blue, blue);
                end
            end
            if (in_valid && !in_stall)
                rgb_expected_q = {rgb_expected_q,
                                  predict_rgb(luma, chroma_blue, chroma_red, offsets)};
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LUMA_OFFSET: offsets.luma = cfg_data;
                    REG_BLUE_OFFSET: offsets.blue = cfg_data;
                    REG_RED_OFFSET:  offsets.red  = cfg_data;
                    default: ;
                endcase
            end
            depth = rgb_expected_q.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
module testbench;
    import yuv2rgb_pkg::*;

    // flow-control patterns, one per phase in rotation
    typedef enum int {
        FLOW_FREE,
        FLOW_SENDER_IDLE,
        FLOW_RECEIVER_STALL,
        FLOW_BOTH
    } flow_t;

    // index past the last register, writes there must be dropped
    localparam cfg_index_t REG_SPARE = 2'd3;

    localparam logic [CfgW-1:0] OffMin  = 9'h100;   // -256
    localparam logic [CfgW-1:0] OffMax  = 9'h0FF;   // +255
    localparam logic [CfgW-1:0] OffZero = 9'h000;

    localparam int NumPhases   = 13;
    localparam int PhasePixels = 107;
    localparam int QuietLimit  = 4000;
    localparam int NumDirected = 20;

    // directed pixels {luma, chroma_blue, chroma_red}: corners, grays, clamp cases
    localparam logic [23:0] Directed [NumDirected] = '{
        24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
        24'hFFFF00, 24'hFF00FF, 24'h00FFFF, 24'h808080, 24'h108080,
        24'hEB8080, 24'h800080, 24'h80FF80, 24'h808000, 24'h8080FF,
        24'h010101, 24'hFEFEFE, 24'h55AA55, 24'hAA55AA, 24'h008080
    };

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [7:0]       luma;
    logic [7:0]       chroma_blue;
    logic [7:0]       chroma_red;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             cfg_we;
    cfg_index_t       cfg_index;
    logic [CfgW-1:0]  cfg_data;

    int mismatches;
    int pending;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    yuv_to_rgb_pixel_converter_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .luma        (luma),
        .chroma_blue (chroma_blue),
        .chroma_red  (chroma_red),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // watches both channels and the register port, predicts and compares
    yuv_to_rgb_checker u_rgb_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .luma        (luma),
        .chroma_blue (chroma_blue),
        .chroma_red  (chroma_red),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    // clock, period 2
    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // samples lean toward the extremes one time in eight
    function automatic logic [7:0] pick_sample();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    // half full range, half small offsets so outputs are not all clamped
    function automatic logic [CfgW-1:0] pick_offset();
        int k;
        if ($urandom_range(0, 1))
            return CfgW'($urandom_range(0, 511));
        k = int'($urandom_range(0, 63)) - 32;
        return CfgW'(k);
    endfunction

    // receiver side: stall decided fresh each cycle
    always @(posedge clk)
        out_stall <= roll(recv_stall_pct);

    // watchdog: cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic set_flow(flow_t mode);
        case (mode)
            FLOW_FREE:
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            FLOW_SENDER_IDLE:
            begin
                send_gap_pct   = 78;
                recv_stall_pct = 0;
            end
            FLOW_RECEIVER_STALL:
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 78;
            end
            default:
            begin
                send_gap_pct   = 26;
                recv_stall_pct = 26;
            end
        endcase
    endtask

    // called at a rising edge; returns at the edge where the beat was taken
    task automatic send_pixel(logic [7:0] y, logic [7:0] u, logic [7:0] v);
        bit taken;
        while (roll(send_gap_pct))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        luma        <= y;
        chroma_blue <= u;
        chroma_red  <= v;
        // stall is settled by the falling edge and holds through the next rise
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // one register write per cycle, returns at the edge that took it
    task automatic write_reg(cfg_index_t idx, logic [CfgW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // wait at falling edges until every predicted rgb beat has come out
    task automatic drain();
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int sent;
        logic [CfgW-1:0] off_luma;
        logic [CfgW-1:0] off_blue;
        logic [CfgW-1:0] off_red;
        sent        = 0;
        in_valid    <= 1'b0;
        luma        <= '0;
        chroma_blue <= '0;
        chroma_red  <= '0;
        cfg_we      <= 1'b0;
        cfg_index   <= REG_LUMA_OFFSET;
        cfg_data    <= '0;
        rst_n       <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < NumPhases; phase++)
        begin
            // block must be empty before the offsets move
            drain();
            set_flow(flow_t'(phase % 4));
            @(posedge clk);

            // phase 0 runs on the reset offsets, then the extremes, then random
            case (phase)
                1:
                begin
                    off_luma = OffMin;
                    off_blue = OffMin;
                    off_red  = OffMin;
                end
                2:
                begin
                    off_luma = OffMax;
                    off_blue = OffMax;
                    off_red  = OffMax;
                end
                3:
                begin
                    off_luma = OffMax;
                    off_blue = OffMin;
                    off_red  = OffZero;
                end
                4:
                begin
                    off_luma = OffMin;
                    off_blue = OffMax;
                    off_red  = OffMax;
                end
                default:
                begin
                    off_luma = pick_offset();
                    off_blue = pick_offset();
                    off_red  = pick_offset();
                end
            endcase
            if (phase > 0)
            begin
                write_reg(REG_LUMA_OFFSET, off_luma);
                write_reg(REG_BLUE_OFFSET, off_blue);
                write_reg(REG_RED_OFFSET, off_red);
            end
            // stray write last so a wrongly decoded index would stick
            write_reg(REG_SPARE, CfgW'($urandom_range(0, 511)));
            cfg_we <= 1'b0;

            if (phase == 0)
            begin
                for (int i = 0; i < NumDirected; i++)
                begin
                    send_pixel(Directed[i][23:16], Directed[i][15:8], Directed[i][7:0]);
                    sent++;
                end
            end
            else
            begin
                for (int i = 0; i < PhasePixels; i++)
                begin
                    send_pixel(pick_sample(), pick_sample(), pick_sample());
                    sent++;
                end
            end
            in_valid <= 1'b0;
        end

        // let the two pipeline stages empty, then a few spare cycles
        drain();
        repeat (8) @(posedge clk);

        $display("covered %0d pixels over %0d offset settings, extremes included,", sent,
                 NumPhases);
        $display("under free flow, sender gaps, receiver stalls and both mixed");
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/yuv2rgb_pkg.sv
rtl/yuv2rgb_matrix.sv
rtl/yuv_to_rgb_pixel_converter_core.sv
bench/yuv_to_rgb_checker.sv
bench/testbench.sv
